// File: hw/rtl/rau_pkg.sv
package rau_pkg;

	// action codes
	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_SUB = 3'd1;
	localparam logic [2:0] ACT_MUL = 3'd2;
	localparam logic [2:0] ACT_DIV = 3'd3;
	localparam logic [2:0] ACT_EQ  = 3'd4;

	// error codes
	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_ZDEN = 2'd1;
	localparam logic [1:0] ERR_DIVZ = 2'd2;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] left_num;
		logic signed [31:0] left_den;
		logic signed [31:0] right_num;
		logic signed [31:0] right_den;
	} rau_in_t;

	typedef struct packed {
		logic signed [63:0] result_num;
		logic [62:0]        result_den;
		logic               is_equal;
		logic [1:0]         error_code;
	} rau_out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_GO_A,
		S_RED_A,
		S_GO_B,
		S_RED_B,
		S_MUL_P,
		S_MUL_Q,
		S_MUL_D,
		S_GO_R,
		S_RED_R,
		S_DONE
	} top_state_t;

	typedef enum logic [2:0] {
		R_IDLE,
		R_TWO,
		R_ODD,
		R_DIV_N,
		R_DIV_D
	} red_state_t;

endpackage

// File: hw/rtl/rau_reduce.sv
module rau_reduce #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] qn,
	output logic [W-1:0] qd
);

	localparam int CW = $clog2(W);

	rau_pkg::red_state_t st_q, st_nxt;
	logic [W-1:0]  u_q, v_q, n_sh_q, d_sh_q, rem_q, quo_q, qn_q, qd_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [W:0]    t;
	logic          ge;
	logic [W:0]    t_sub;
	logic [W-1:0]  rem_n, quo_n;

	// one restoring divide step, divisor is the odd gcd part
	always_comb begin
		t     = {rem_q, quo_q[W-1]};
		ge    = (t >= {1'b0, u_q});
		t_sub = t - {1'b0, u_q};
		rem_n = ge ? t_sub[W-1:0] : t[W-1:0];
		quo_n = {quo_q[W-2:0], ge};
	end

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			rau_pkg::R_IDLE: begin
				if (start && (num != '0))
					st_nxt = rau_pkg::R_TWO;
			end
			rau_pkg::R_TWO: begin
				if (u_q[0] || v_q[0])
					st_nxt = rau_pkg::R_ODD;
			end
			rau_pkg::R_ODD: begin
				if (v_q == '0)
					st_nxt = rau_pkg::R_DIV_N;
			end
			rau_pkg::R_DIV_N: begin
				if (cnt_q == '0)
					st_nxt = rau_pkg::R_DIV_D;
			end
			rau_pkg::R_DIV_D: begin
				if (cnt_q == '0)
					st_nxt = rau_pkg::R_IDLE;
			end
			default: st_nxt = rau_pkg::R_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= rau_pkg::R_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_nxt;
			done_q <= ((st_q == rau_pkg::R_IDLE) && start && (num == '0)) ||
			          ((st_q == rau_pkg::R_DIV_D) && (cnt_q == '0));
		end
	end

	// binary gcd steps, then two exact divisions
	always_ff @(posedge clk) begin
		case (st_q)
			rau_pkg::R_IDLE: begin
				if (start) begin
					u_q  <= num;
					v_q  <= den;
					qn_q <= '0;
					qd_q <= W'(1);
				end
			end
			rau_pkg::R_TWO: begin
				if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
				end else begin
					n_sh_q <= u_q;
					d_sh_q <= v_q;
				end
			end
			rau_pkg::R_ODD: begin
				if (v_q == '0) begin
					quo_q <= n_sh_q;
					rem_q <= '0;
					cnt_q <= CW'(W - 1);
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q > v_q) begin
					u_q <= v_q;
					v_q <= u_q - v_q;
				end else begin
					v_q <= v_q - u_q;
				end
			end
			rau_pkg::R_DIV_N: begin
				if (cnt_q == '0) begin
					qn_q  <= quo_n;
					quo_q <= d_sh_q;
					rem_q <= '0;
					cnt_q <= CW'(W - 1);
				end else begin
					quo_q <= quo_n;
					rem_q <= rem_n;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			rau_pkg::R_DIV_D: begin
				if (cnt_q == '0) begin
					qd_q <= quo_n;
				end else begin
					quo_q <= quo_n;
					rem_q <= rem_n;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign qn   = qn_q;
	assign qd   = qd_q;

endmodule

// File: hw/rtl/rational_arithmetic_unit.sv
// channel  | handshake             | payload
// req      | req_valid, req_ready  | req  (rau_pkg::rau_in_t)
// rsp      | rsp_valid, rsp_ready  | rsp  (rau_pkg::rau_out_t)
//
// one item at a time; req_ready is high only while the sequencer is idle.
// each reduction runs a binary gcd (one shift or subtract per cycle) and
// then two exact restoring divides by the odd gcd part.
// an add item takes three reductions and three multiplies, while
// zero-denominator items skip them and go straight to the response.
// arst_n clears the sequencers and the result valid; a stalled rsp holds.
module rational_arithmetic_unit #(
	parameter int OPERAND_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rau_pkg::rau_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rau_pkg::rau_out_t rsp
);

	localparam int MW = OPERAND_BITS;
	localparam int PW = 2 * OPERAND_BITS;

	rau_pkg::top_state_t st_q, st_nxt;
	logic [2:0]        act_q;
	logic [MW-1:0]     an_q, ad_q, bn_q, bd_q;
	logic              a_neg_q, b_neg_q, s_q;
	logic [PW-1:0]     p_q, q_q, d_q;
	rau_pkg::rau_out_t res_q, rsp_q;
	logic              rsp_valid_q;

	logic [MW-1:0] ln_raw, ld_raw, rn_raw, rd_raw;
	logic [MW-1:0] ln_mag, ld_mag, rn_mag, rd_mag;
	logic          zden;
	logic          red_start, red_done;
	logic [PW-1:0] red_num, red_den, red_qn, red_qd;
	logic [MW-1:0] mul_x, mul_y;
	logic [PW-1:0] prod;
	logic          sp, sq, s_c;
	logic [PW-1:0] m_c;
	logic          out_go;
	logic          b_neg_r;
	logic [63:0]   num64;

	// operand sign handling
	always_comb begin
		ln_raw = req.left_num[MW-1:0];
		ld_raw = req.left_den[MW-1:0];
		rn_raw = req.right_num[MW-1:0];
		rd_raw = req.right_den[MW-1:0];
		ln_mag = ln_raw[MW-1] ? (~ln_raw + 1'b1) : ln_raw;
		ld_mag = ld_raw[MW-1] ? (~ld_raw + 1'b1) : ld_raw;
		rn_mag = rn_raw[MW-1] ? (~rn_raw + 1'b1) : rn_raw;
		rd_mag = rd_raw[MW-1] ? (~rd_raw + 1'b1) : rd_raw;
		zden   = (ld_raw == '0) || (rd_raw == '0);
	end

	// shared multiplier operand select
	always_comb begin
		mul_x = an_q;
		mul_y = (act_q == rau_pkg::ACT_MUL) ? bn_q : bd_q;
		case (st_q)
			rau_pkg::S_MUL_Q: begin
				mul_x = bn_q;
				mul_y = ad_q;
			end
			rau_pkg::S_MUL_D: begin
				mul_x = ad_q;
				mul_y = (act_q == rau_pkg::ACT_DIV) ? bn_q : bd_q;
			end
			default: ;
		endcase
		prod = PW'(mul_x) * PW'(mul_y);
	end

	// signed sum of the cross products; mul and div pass the first product on
	always_comb begin
		sp = a_neg_q;
		sq = (act_q == rau_pkg::ACT_SUB) ? !b_neg_q : b_neg_q;
		if (q_q == '0)
			sq = sp;
		if (p_q == '0)
			sp = sq;
		if ((act_q != rau_pkg::ACT_ADD) && (act_q != rau_pkg::ACT_SUB)) begin
			m_c = p_q;
			s_c = a_neg_q ^ b_neg_q;
		end else if (sp == sq) begin
			m_c = p_q + q_q;
			s_c = sp;
		end else if (p_q >= q_q) begin
			m_c = p_q - q_q;
			s_c = sp;
		end else begin
			m_c = q_q - p_q;
			s_c = sq;
		end
	end

	// sequencer next state and reducer requests
	always_comb begin
		st_nxt    = st_q;
		req_ready = 1'b0;
		red_start = 1'b0;
		red_num   = PW'(an_q);
		red_den   = PW'(ad_q);
		out_go    = !rsp_valid_q || rsp_ready;
		case (st_q)
			rau_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (zden || (req.action > rau_pkg::ACT_EQ))
						st_nxt = rau_pkg::S_DONE;
					else
						st_nxt = rau_pkg::S_GO_A;
				end
			end
			rau_pkg::S_GO_A: begin
				red_start = 1'b1;
				st_nxt    = rau_pkg::S_RED_A;
			end
			rau_pkg::S_RED_A: begin
				if (red_done)
					st_nxt = rau_pkg::S_GO_B;
			end
			rau_pkg::S_GO_B: begin
				red_start = 1'b1;
				red_num   = PW'(bn_q);
				red_den   = PW'(bd_q);
				st_nxt    = rau_pkg::S_RED_B;
			end
			rau_pkg::S_RED_B: begin
				if (red_done) begin
					if (act_q == rau_pkg::ACT_EQ)
						st_nxt = rau_pkg::S_DONE;
					else if ((act_q == rau_pkg::ACT_DIV) && (red_qn == '0))
						st_nxt = rau_pkg::S_DONE;
					else
						st_nxt = rau_pkg::S_MUL_P;
				end
			end
			rau_pkg::S_MUL_P: st_nxt = rau_pkg::S_MUL_Q;
			rau_pkg::S_MUL_Q: st_nxt = rau_pkg::S_MUL_D;
			rau_pkg::S_MUL_D: st_nxt = rau_pkg::S_GO_R;
			rau_pkg::S_GO_R: begin
				red_start = 1'b1;
				red_num   = m_c;
				red_den   = d_q;
				st_nxt    = rau_pkg::S_RED_R;
			end
			rau_pkg::S_RED_R: begin
				if (red_done)
					st_nxt = rau_pkg::S_DONE;
			end
			rau_pkg::S_DONE: begin
				if (out_go)
					st_nxt = rau_pkg::S_IDLE;
			end
			default: st_nxt = rau_pkg::S_IDLE;
		endcase
	end

	rau_reduce #(
		.W(PW)
	) u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.num    (red_num),
		.den    (red_den),
		.done   (red_done),
		.qn     (red_qn),
		.qd     (red_qd)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= rau_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if ((st_q == rau_pkg::S_DONE) && out_go)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign b_neg_r = b_neg_q && (red_qn != '0);
	assign num64   = 64'(red_qn);

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			rau_pkg::S_IDLE: begin
				if (req_valid) begin
					act_q              <= req.action;
					an_q               <= ln_mag;
					ad_q               <= ld_mag;
					bn_q               <= rn_mag;
					bd_q               <= rd_mag;
					a_neg_q            <= ln_raw[MW-1] ^ ld_raw[MW-1];
					b_neg_q            <= rn_raw[MW-1] ^ rd_raw[MW-1];
					res_q.result_num   <= '0;
					res_q.result_den   <= 63'd1;
					res_q.is_equal     <= 1'b0;
					res_q.error_code   <= zden ? rau_pkg::ERR_ZDEN : rau_pkg::ERR_OK;
				end
			end
			rau_pkg::S_RED_A: begin
				if (red_done) begin
					an_q    <= red_qn[MW-1:0];
					ad_q    <= red_qd[MW-1:0];
					a_neg_q <= a_neg_q && (red_qn != '0);
				end
			end
			rau_pkg::S_RED_B: begin
				if (red_done) begin
					bn_q    <= red_qn[MW-1:0];
					bd_q    <= red_qd[MW-1:0];
					b_neg_q <= b_neg_r;
					if (act_q == rau_pkg::ACT_EQ)
						res_q.is_equal <= (a_neg_q == b_neg_r) &&
						                  (an_q == red_qn[MW-1:0]) &&
						                  (ad_q == red_qd[MW-1:0]);
					if ((act_q == rau_pkg::ACT_DIV) && (red_qn == '0))
						res_q.error_code <= rau_pkg::ERR_DIVZ;
				end
			end
			rau_pkg::S_MUL_P: p_q <= prod;
			rau_pkg::S_MUL_Q: q_q <= prod;
			rau_pkg::S_MUL_D: d_q <= prod;
			rau_pkg::S_GO_R:  s_q <= s_c;
			rau_pkg::S_RED_R: begin
				if (red_done) begin
					res_q.result_num <= (s_q && (red_qn != '0)) ? (64'd0 - num64) : num64;
					res_q.result_den <= 63'(red_qd);
				end
			end
			rau_pkg::S_DONE: begin
				if (out_go)
					rsp_q <= res_q;
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// flagged items carry zero over one
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.error_code != rau_pkg::ERR_OK)) |->
		((rsp.result_num == '0) && (rsp.result_den == 63'd1)))
		else $error("error result is not zero over one");

	// denominator is never zero
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.result_den != '0))
		else $error("zero result denominator");

	// equality flag only on error-free items
	a_eq_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.is_equal) |-> (rsp.error_code == rau_pkg::ERR_OK))
		else $error("equality flag with error");

	// busy after an accepted item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("ready right after accept");
`endif

endmodule
